FILE: hw/rtl/bmmh_pkg.sv
// bmmh_pkg: shared constants, codes, state encoding and result type of the bounded min-max heap
// no dependencies; used by bmmh_engine and bounded_min_max_heap_core
`timescale 1ns / 1ps

package bmmh_pkg;

   // storage geometry
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int IDX_W  = ADDR_W + 2;
   localparam int MSB_W  = $clog2(ADDR_W + 1);
   localparam int WORD_W = 64;
   localparam int POS_W  = 10;
   localparam int CAP_W  = 11;
   localparam int SCAN_N = 6;

   // command codes
   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_TAKE  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   // status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_EVICTED  = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_REMOVED  = 3'd3;
   localparam logic [2:0] ST_NOTHING  = 3'd4;
   localparam logic [2:0] ST_CLEARED  = 3'd5;

   typedef enum logic [23:0] {
      S_IDLE      = 24'h000001,
      S_START     = 24'h000002,
      S_PUSH_PAR  = 24'h000004,
      S_FULL_A    = 24'h000008,
      S_FULL_B    = 24'h000010,
      S_FULL_C    = 24'h000020,
      S_FULL_D    = 24'h000040,
      S_EVICT     = 24'h000080,
      S_LOAD_B    = 24'h000100,
      S_LOAD_C    = 24'h000200,
      S_REP       = 24'h000400,
      S_REP_PAR   = 24'h000800,
      S_CLIMB     = 24'h001000,
      S_CLIMB_CMP = 24'h002000,
      S_SINK      = 24'h004000,
      S_SCAN      = 24'h008000,
      S_DECIDE    = 24'h010000,
      S_FIN       = 24'h020000,
      S_SWAPPAR   = 24'h040000,
      S_SUM_A     = 24'h080000,
      S_SUM_B     = 24'h100000,
      S_SUM_C     = 24'h200000,
      S_SUM_D     = 24'h400000,
      S_OUT       = 24'h800000
   } state_type;

   // what follows a climb
   typedef enum logic [1:0] {
      POST_NONE    = 2'd0,
      POST_ALWAYS  = 2'd1,
      POST_IFSTILL = 2'd2
   } post_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [WORD_W-1:0] out_word;
      logic [WORD_W-1:0] best_word;
      logic              best_valid;
      logic [WORD_W-1:0] worst_word;
      logic              worst_valid;
      logic [CNT_W-1:0]  entry_count;
   } res_type;

   // position lies on a min level when the bit length of idx+1 is odd
   function automatic logic min_level(input logic [ADDR_W-1:0] idx);
      logic [ADDR_W:0]  v;
      logic [MSB_W-1:0] msb;
      v   = {1'b0, idx} + (ADDR_W + 1)'(1);
      msb = '0;
      for (int b = 0; b <= ADDR_W; b++) begin
         if (v[b]) msb = MSB_W'(b);
      end
      return ~msb[0];
   endfunction

endpackage

FILE: hw/rtl/bounded_min_max_heap_core.sv
// bounded_min_max_heap_core: runs one transaction at a time and accepts a new request only after
// the previous result has entered the response register, which holds it until rsp_ready
// the single ram read port sets the pace: a sink step scans up to six entries per grand level
// reset clears the entry count and sets capacity_limit to 1024; the heap ram is not cleared
// depends on bmmh_pkg, bmmh_ram and bmmh_engine
`timescale 1ns / 1ps

module bounded_min_max_heap_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [bmmh_pkg::WORD_W-1:0]   req_data_word,
   input  logic [bmmh_pkg::POS_W-1:0]    req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [bmmh_pkg::WORD_W-1:0]   rsp_out_word,
   output logic [bmmh_pkg::WORD_W-1:0]   rsp_best_word,
   output logic                          rsp_best_valid,
   output logic [bmmh_pkg::WORD_W-1:0]   rsp_worst_word,
   output logic                          rsp_worst_valid,
   output logic [bmmh_pkg::CNT_W-1:0]    rsp_entry_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bmmh_pkg::CAP_W-1:0]    csr_capacity_limit
);

   logic [bmmh_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [bmmh_pkg::CNT_W-1:0]  eff_cap;
   logic                        rsp_valid_ff, rsp_valid_in;
   bmmh_pkg::res_type           rsp_ff, rsp_in;
   bmmh_pkg::res_type           res;
   logic                        res_valid;
   logic                        slot_free;
   logic                        wr_en, rd_en;
   logic [bmmh_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [bmmh_pkg::WORD_W-1:0] wr_data, rd_data;

   // capacity register, clamped to 1..DEPTH
   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_capacity_limit : cap_ff;
   always_comb begin
      if (cap_ff == '0)
         eff_cap = bmmh_pkg::CNT_W'(1);
      else if (32'(cap_ff) > bmmh_pkg::DEPTH)
         eff_cap = bmmh_pkg::CNT_W'(bmmh_pkg::DEPTH);
      else
         eff_cap = bmmh_pkg::CNT_W'(cap_ff);
   end

   // response register
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = res_valid ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= bmmh_pkg::CAP_W'(bmmh_pkg::DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_out_word    = rsp_ff.out_word;
   assign rsp_best_word   = rsp_ff.best_word;
   assign rsp_best_valid  = rsp_ff.best_valid;
   assign rsp_worst_word  = rsp_ff.worst_word;
   assign rsp_worst_valid = rsp_ff.worst_valid;
   assign rsp_entry_count = rsp_ff.entry_count;

   bmmh_ram #(
      .WIDTH (bmmh_pkg::WORD_W),
      .DEPTH (bmmh_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmmh_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_word (req_data_word),
      .req_position  (req_position),
      .cap           (eff_cap),
      .slot_free     (slot_free),
      .res_valid     (res_valid),
      .res           (res),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   // count never exceeds the storage depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_entry_count) <= bmmh_pkg::DEPTH))
      else $error("entry count beyond depth");

   // a full heap is never empty
   a_worst_best: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_worst_valid) |-> rsp_best_valid)
      else $error("worst valid without best valid");

   // an insert or evict always leaves at least one entry
   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == bmmh_pkg::ST_INSERTED ||
                     rsp_status == bmmh_pkg::ST_EVICTED)) |-> rsp_best_valid)
      else $error("insert left heap empty");

   // no new transaction while a result is being worked out
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_ready)
      else $error("request accepted while result pending");

endmodule

FILE: hw/rtl/bmmh_ram.sv
// bmmh_ram: generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bmmh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bmmh_engine.sv
// bmmh_engine: sequencer that runs push, pop, take and clear on the heap ram, one access a cycle
// depends on bmmh_pkg; drives the ports of one bmmh_ram
`timescale 1ns / 1ps

module bmmh_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_cmd,
   input  logic [bmmh_pkg::WORD_W-1:0]  req_data_word,
   input  logic [bmmh_pkg::POS_W-1:0]   req_position,
   input  logic [bmmh_pkg::CNT_W-1:0]   cap,
   input  logic                         slot_free,
   output logic                         res_valid,
   output bmmh_pkg::res_type            res,
   output logic                         wr_en,
   output logic [bmmh_pkg::ADDR_W-1:0]  wr_addr,
   output logic [bmmh_pkg::WORD_W-1:0]  wr_data,
   output logic                         rd_en,
   output logic [bmmh_pkg::ADDR_W-1:0]  rd_addr,
   input  logic [bmmh_pkg::WORD_W-1:0]  rd_data
);

   localparam int AW = bmmh_pkg::ADDR_W;
   localparam int CW = bmmh_pkg::CNT_W;
   localparam int IW = bmmh_pkg::IDX_W;
   localparam int WW = bmmh_pkg::WORD_W;

   bmmh_pkg::state_type state_ff, state_in;
   bmmh_pkg::post_type  post_ff, post_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [WW-1:0] word_ff, word_in;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] i_ff, i_in;
   logic [WW-1:0] v_ff, v_in;
   logic          hi_ff, hi_in;
   logic          moved_ff, moved_in;
   logic [AW-1:0] s_i_ff, s_i_in;
   logic [WW-1:0] s_val_ff, s_val_in;
   logic          s_hi_ff, s_hi_in;
   logic [2:0]    status_ff, status_in;
   logic [WW-1:0] ow_ff, ow_in;
   logic [WW-1:0] t1_ff, t1_in;
   logic [WW-1:0] ev_ff, ev_in;
   logic [AW-1:0] mp_ff, mp_in;
   logic [2:0]    scan_k_ff, scan_k_in;
   logic          scan_have_ff, scan_have_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [WW-1:0] best_val_ff, best_val_in;
   logic [WW-1:0] cv0_ff, cv0_in;
   logic [WW-1:0] cv1_ff, cv1_in;
   logic [WW-1:0] h0_ff, h0_in;
   logic [WW-1:0] h1_ff, h1_in;
   logic [WW-1:0] h2_ff, h2_in;

   // index arithmetic around the current position
   logic [IW-1:0] c_idx, g_idx, cand, n_ext;
   logic [AW-1:0] par_i, gpar_i, par_n, bpar;
   logic [CW-1:0] nn;
   logic          mn;
   logic          climb_fin;
   logic          full;
   logic [WW-1:0] worst;

   assign c_idx  = {1'b0, i_ff, 1'b1};
   assign g_idx  = {i_ff, 2'b11};
   assign n_ext  = {1'b0, n_ff};
   assign par_i  = (i_ff - AW'(1)) >> 1;
   assign gpar_i = (i_ff - AW'(3)) >> 2;
   assign par_n  = (n_ff[AW-1:0] - AW'(1)) >> 1;
   assign bpar   = (best_idx_ff - AW'(1)) >> 1;
   assign nn     = n_ff - CW'(1);
   assign mn     = bmmh_pkg::min_level(i_ff);

   // candidate list of a sink step: two children, then four grandchildren
   always_comb begin
      case (scan_k_ff)
         3'd0:    cand = c_idx;
         3'd1:    cand = c_idx + IW'(1);
         3'd2:    cand = g_idx;
         3'd3:    cand = g_idx + IW'(1);
         3'd4:    cand = g_idx + IW'(2);
         default: cand = g_idx + IW'(3);
      endcase
   end

   // summary of the heap after the operation
   assign full = (n_ff != '0) && (n_ff >= cap);
   always_comb begin
      if (n_ff < CW'(3)) worst = (n_ff == CW'(1)) ? h0_ff : h1_ff;
      else               worst = (h1_ff < h2_ff) ? h2_ff : h1_ff;
   end

   always_comb begin
      res.status      = status_ff;
      res.out_word    = ow_ff;
      res.best_word   = (n_ff != '0) ? h0_ff : '0;
      res.best_valid  = (n_ff != '0);
      res.worst_word  = full ? worst : '0;
      res.worst_valid = full;
      res.entry_count = n_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      post_in      = post_ff;
      cmd_in       = cmd_ff;
      word_in      = word_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      v_in         = v_ff;
      hi_in        = hi_ff;
      moved_in     = moved_ff;
      s_i_in       = s_i_ff;
      s_val_in     = s_val_ff;
      s_hi_in      = s_hi_ff;
      status_in    = status_ff;
      ow_in        = ow_ff;
      t1_in        = t1_ff;
      ev_in        = ev_ff;
      mp_in        = mp_ff;
      scan_k_in    = scan_k_ff;
      scan_have_in = scan_have_ff;
      rd_idx_in    = rd_idx_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      cv0_in       = cv0_ff;
      cv1_in       = cv1_ff;
      h0_in        = h0_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = i_ff;
      wr_data      = v_ff;
      rd_en        = 1'b0;
      rd_addr      = i_ff;
      climb_fin    = 1'b0;

      case (state_ff)
         bmmh_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_cmd;
               word_in  = req_data_word;
               i_in     = AW'(req_position);
               state_in = bmmh_pkg::S_START;
            end
         end

         // dispatch on the command
         bmmh_pkg::S_START: begin
            ow_in = '0;
            case (cmd_ff)
               bmmh_pkg::CMD_PUSH: begin
                  if (n_ff < cap) begin
                     status_in = bmmh_pkg::ST_INSERTED;
                     i_in      = n_ff[AW-1:0];
                     v_in      = word_ff;
                     n_in      = n_ff + CW'(1);
                     if (n_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = word_ff;
                        state_in = bmmh_pkg::S_SUM_A;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = par_n;
                        state_in = bmmh_pkg::S_PUSH_PAR;
                     end
                  end else begin
                     state_in = bmmh_pkg::S_FULL_A;
                  end
               end
               bmmh_pkg::CMD_POP: begin
                  if (n_ff == '0) begin
                     status_in = bmmh_pkg::ST_NOTHING;
                     state_in  = bmmh_pkg::S_SUM_A;
                  end else begin
                     status_in = bmmh_pkg::ST_REMOVED;
                     i_in      = '0;
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                     state_in  = bmmh_pkg::S_LOAD_B;
                  end
               end
               bmmh_pkg::CMD_TAKE: begin
                  if ({1'b0, i_ff} < n_ff) begin
                     status_in = bmmh_pkg::ST_REMOVED;
                     rd_en     = 1'b1;
                     rd_addr   = i_ff;
                     state_in  = bmmh_pkg::S_LOAD_B;
                  end else begin
                     status_in = bmmh_pkg::ST_NOTHING;
                     state_in  = bmmh_pkg::S_SUM_A;
                  end
               end
               default: begin
                  n_in      = '0;
                  status_in = bmmh_pkg::ST_CLEARED;
                  state_in  = bmmh_pkg::S_SUM_A;
               end
            endcase
         end

         // new word against its parent, then climb
         bmmh_pkg::S_PUSH_PAR: begin
            post_in  = bmmh_pkg::POST_NONE;
            moved_in = 1'b0;
            if (mn ? (rd_data < v_ff) : (v_ff < rd_data)) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               i_in    = par_i;
               hi_in   = mn;
            end else begin
               hi_in   = ~mn;
            end
            state_in = bmmh_pkg::S_CLIMB;
         end

         // full heap: locate the largest word
         bmmh_pkg::S_FULL_A: begin
            rd_en = 1'b1;
            if (n_ff >= CW'(3)) begin
               rd_addr  = AW'(1);
               state_in = bmmh_pkg::S_FULL_B;
            end else begin
               mp_in    = nn[AW-1:0];
               rd_addr  = nn[AW-1:0];
               state_in = bmmh_pkg::S_FULL_D;
            end
         end
         bmmh_pkg::S_FULL_B: begin
            t1_in    = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'(2);
            state_in = bmmh_pkg::S_FULL_C;
         end
         bmmh_pkg::S_FULL_C: begin
            if (t1_ff < rd_data) begin
               mp_in = AW'(2);
               ev_in = rd_data;
            end else begin
               mp_in = AW'(1);
               ev_in = t1_ff;
            end
            state_in = bmmh_pkg::S_EVICT;
         end
         bmmh_pkg::S_FULL_D: begin
            ev_in    = rd_data;
            state_in = bmmh_pkg::S_EVICT;
         end
         bmmh_pkg::S_EVICT: begin
            if (word_ff < ev_ff) begin
               status_in = bmmh_pkg::ST_EVICTED;
               ow_in     = ev_ff;
               i_in      = mp_ff;
               v_in      = word_ff;
               state_in  = bmmh_pkg::S_REP;
            end else begin
               status_in = bmmh_pkg::ST_REJECTED;
               ow_in     = word_ff;
               state_in  = bmmh_pkg::S_SUM_A;
            end
         end

         // removal: take the word out, pull the last entry into the hole
         bmmh_pkg::S_LOAD_B: begin
            ow_in = rd_data;
            n_in  = nn;
            if ({1'b0, i_ff} < nn) begin
               rd_en    = 1'b1;
               rd_addr  = nn[AW-1:0];
               state_in = bmmh_pkg::S_LOAD_C;
            end else begin
               state_in = bmmh_pkg::S_SUM_A;
            end
         end
         bmmh_pkg::S_LOAD_C: begin
            v_in = rd_data;
            if (cmd_ff == bmmh_pkg::CMD_POP) begin
               hi_in    = 1'b0;
               state_in = bmmh_pkg::S_SINK;
            end else begin
               state_in = bmmh_pkg::S_REP;
            end
         end

         // repair around the carried word at i
         bmmh_pkg::S_REP: begin
            if (i_ff == '0) begin
               hi_in    = 1'b0;
               state_in = bmmh_pkg::S_SINK;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = par_i;
               state_in = bmmh_pkg::S_REP_PAR;
            end
         end
         bmmh_pkg::S_REP_PAR: begin
            moved_in = 1'b0;
            if (mn ? (rd_data < v_ff) : (v_ff < rd_data)) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               s_i_in   = i_ff;
               s_val_in = rd_data;
               s_hi_in  = ~mn;
               post_in  = bmmh_pkg::POST_ALWAYS;
               i_in     = par_i;
               hi_in    = mn;
            end else begin
               post_in  = bmmh_pkg::POST_IFSTILL;
               hi_in    = ~mn;
            end
            state_in = bmmh_pkg::S_CLIMB;
         end

         // climb through grandparents
         bmmh_pkg::S_CLIMB: begin
            if (i_ff >= AW'(3)) begin
               rd_en    = 1'b1;
               rd_addr  = gpar_i;
               state_in = bmmh_pkg::S_CLIMB_CMP;
            end else begin
               climb_fin = 1'b1;
            end
         end
         bmmh_pkg::S_CLIMB_CMP: begin
            if (hi_ff ? (rd_data < v_ff) : (v_ff < rd_data)) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               i_in     = gpar_i;
               moved_in = 1'b1;
               state_in = bmmh_pkg::S_CLIMB;
            end else begin
               climb_fin = 1'b1;
            end
         end

         // sink: scan children and grandchildren
         bmmh_pkg::S_SINK: begin
            if (c_idx >= n_ext) begin
               wr_en    = 1'b1;
               state_in = bmmh_pkg::S_SUM_A;
            end else begin
               scan_k_in    = '0;
               scan_have_in = 1'b0;
               state_in     = bmmh_pkg::S_SCAN;
            end
         end
         bmmh_pkg::S_SCAN: begin
            if (scan_have_ff) begin
               if ((scan_k_ff == 3'd1) ||
                   (hi_ff ? (best_val_ff < rd_data) : (rd_data < best_val_ff))) begin
                  best_idx_in = rd_idx_ff;
                  best_val_in = rd_data;
               end
               if (scan_k_ff == 3'd1) cv0_in = rd_data;
               if (scan_k_ff == 3'd2) cv1_in = rd_data;
            end
            if ((scan_k_ff < 3'(bmmh_pkg::SCAN_N)) && (cand < n_ext)) begin
               rd_en        = 1'b1;
               rd_addr      = cand[AW-1:0];
               rd_idx_in    = cand[AW-1:0];
               scan_have_in = 1'b1;
               scan_k_in    = scan_k_ff + 3'd1;
            end else begin
               scan_have_in = 1'b0;
               state_in     = bmmh_pkg::S_DECIDE;
            end
         end
         bmmh_pkg::S_DECIDE: begin
            wr_en = 1'b1;
            if (!(hi_ff ? (v_ff < best_val_ff) : (best_val_ff < v_ff))) begin
               state_in = bmmh_pkg::S_SUM_A;
            end else begin
               wr_data = best_val_ff;
               i_in    = best_idx_ff;
               if ({2'b00, best_idx_ff} < g_idx) begin
                  state_in = bmmh_pkg::S_FIN;
               end else begin
                  mp_in = bpar;
                  ev_in = (bpar == c_idx[AW-1:0]) ? cv0_ff : cv1_ff;
                  if (hi_ff ? (v_ff < ((bpar == c_idx[AW-1:0]) ? cv0_ff : cv1_ff))
                            : (((bpar == c_idx[AW-1:0]) ? cv0_ff : cv1_ff) < v_ff)) begin
                     state_in = bmmh_pkg::S_SWAPPAR;
                  end else begin
                     state_in = bmmh_pkg::S_SINK;
                  end
               end
            end
         end
         bmmh_pkg::S_FIN: begin
            wr_en    = 1'b1;
            state_in = bmmh_pkg::S_SUM_A;
         end
         bmmh_pkg::S_SWAPPAR: begin
            wr_en    = 1'b1;
            wr_addr  = mp_ff;
            v_in     = ev_ff;
            state_in = bmmh_pkg::S_SINK;
         end

         // read the three top entries for the result
         bmmh_pkg::S_SUM_A: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = bmmh_pkg::S_SUM_B;
         end
         bmmh_pkg::S_SUM_B: begin
            h0_in    = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'(1);
            state_in = bmmh_pkg::S_SUM_C;
         end
         bmmh_pkg::S_SUM_C: begin
            h1_in    = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'(2);
            state_in = bmmh_pkg::S_SUM_D;
         end
         bmmh_pkg::S_SUM_D: begin
            h2_in    = rd_data;
            state_in = bmmh_pkg::S_OUT;
         end
         bmmh_pkg::S_OUT: begin
            if (slot_free) begin
               res_valid = 1'b1;
               state_in  = bmmh_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bmmh_pkg::S_IDLE;
         end
      endcase

      // end of a climb: place the word, then maybe sink
      if (climb_fin) begin
         wr_en = 1'b1;
         if (post_ff == bmmh_pkg::POST_ALWAYS) begin
            i_in     = s_i_ff;
            v_in     = s_val_ff;
            hi_in    = s_hi_ff;
            state_in = bmmh_pkg::S_SINK;
         end else if ((post_ff == bmmh_pkg::POST_IFSTILL) && !moved_ff) begin
            state_in = bmmh_pkg::S_SINK;
         end else begin
            state_in = bmmh_pkg::S_SUM_A;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmmh_pkg::S_IDLE;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      post_ff      <= post_in;
      cmd_ff       <= cmd_in;
      word_ff      <= word_in;
      i_ff         <= i_in;
      v_ff         <= v_in;
      hi_ff        <= hi_in;
      moved_ff     <= moved_in;
      s_i_ff       <= s_i_in;
      s_val_ff     <= s_val_in;
      s_hi_ff      <= s_hi_in;
      status_ff    <= status_in;
      ow_ff        <= ow_in;
      t1_ff        <= t1_in;
      ev_ff        <= ev_in;
      mp_ff        <= mp_in;
      scan_k_ff    <= scan_k_in;
      scan_have_ff <= scan_have_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_val_ff  <= best_val_in;
      cv0_ff       <= cv0_in;
      cv1_ff       <= cv1_in;
      h0_ff        <= h0_in;
      h1_ff        <= h1_in;
      h2_ff        <= h2_in;
   end

endmodule
